FILE: src/pba_pkg.sv
// Shared constants, request types and a helper function of the page bitmap allocator.
`timescale 1ns / 1ps
package pba_pkg;

    // Map geometry: one bit per page, WORD_BITS pages to a map word.
    localparam int MAP_WORDS = 32768;
    localparam int WORD_BITS = 32;
    localparam int PAGE_W    = 20;
    localparam int ACTION_W  = 2;

    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int MAP_AW    = $clog2(MAP_WORDS);
    // Summary levels: one bit per map word, then one bit per summary word.
    localparam int SUM_WORDS = MAP_WORDS / WORD_BITS;
    localparam int SUM_AW    = $clog2(SUM_WORDS);
    localparam int TOP_WORDS = SUM_WORDS / WORD_BITS;
    localparam int TOP_AW    = $clog2(TOP_WORDS);

    // Action codes on the request channel.
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd2;

    // Classified operation handed from the front part to the back part.
    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_SET   = 2'd2,
        KIND_CLR   = 2'd3
    } pba_kind_t;

    typedef struct packed {
        pba_kind_t         kind;
        logic [MAP_AW-1:0] word_idx;
        logic [BIT_W-1:0]  bit_idx;
    } pba_cmd_t;

    // Status from the back part to the front part.
    typedef struct packed {
        logic clearing;
    } pba_status_t;

    // Index of the lowest set bit of a word; zero when the word is empty.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/pba_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
`timescale 1ns / 1ps
module pba_front import pba_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [PAGE_W-1:0]   s_page_number,
    input  pba_status_t         status,
    output logic                q_valid,
    input  logic                q_ready,
    output pba_cmd_t            q_cmd
);

    localparam int QD = 2;

    pba_cmd_t          ent_reg [QD];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    pba_cmd_t          cmd;
    logic              push, pop;
    logic [PAGE_W:0]   word_wide;
    logic              in_range;

    // Classify the request: out-of-map pages and unused codes become no-ops.
    assign word_wide = {1'b0, s_page_number} >> BIT_W;
    assign in_range  = word_wide < (PAGE_W + 1)'(MAP_WORDS);

    always_comb begin
        cmd.word_idx = MAP_AW'(word_wide);
        cmd.bit_idx  = s_page_number[BIT_W-1:0];
        priority if (s_action == ACT_ALLOC) begin
            cmd.kind = KIND_ALLOC;
        end else if (s_action == ACT_FREE && in_range) begin
            cmd.kind = KIND_SET;
        end else if (s_action == ACT_MARK && in_range) begin
            cmd.kind = KIND_CLR;
        end else begin
            cmd.kind = KIND_NOP;
        end
    end

    // Two-entry queue towards the back part; closed while the map is cleared.
    assign s_ready = (count_reg != 2'(QD)) && !status.clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != 2'd0;
    assign pop     = q_valid && q_ready;
    assign q_cmd   = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

FILE: src/pba_back.sv
// Back part: bitmap and summary storage, first-fit search and bit updates.
`timescale 1ns / 1ps
module pba_back import pba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  pba_cmd_t          q_cmd,
    output pba_status_t       status,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [PAGE_W-1:0] m_granted_page
);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_FIND_TOP  = 3'd2;
    localparam logic [2:0] ST_FIND_SUM  = 3'd3;
    localparam logic [2:0] ST_FIND_WORD = 3'd4;
    localparam logic [2:0] ST_READ      = 3'd5;
    localparam logic [2:0] ST_UPDATE    = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [MAP_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    pba_kind_t            kind_reg, kind_next;
    logic [MAP_AW-1:0]    word_idx_reg, word_idx_next;
    logic [BIT_W-1:0]     bit_idx_reg, bit_idx_next;
    logic [TOP_WORDS-1:0] top_reg, top_next;
    logic [WORD_BITS-1:0] l2_reg [TOP_WORDS];
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [PAGE_W-1:0]    out_page_reg, out_page_next;

    logic                 map_we, sum_we, l2_we;
    logic [MAP_AW-1:0]    map_waddr, map_raddr;
    logic [WORD_BITS-1:0] map_wdata, map_rdata;
    logic [SUM_AW-1:0]    sum_waddr, sum_raddr;
    logic [WORD_BITS-1:0] sum_wdata, sum_rdata;

    logic                 out_free;
    logic [TOP_AW-1:0]    top_sel;
    logic [BIT_W-1:0]     top_low, l2_low, sum_low, map_low;
    logic [TOP_AW-1:0]    cur_top;
    logic [BIT_W-1:0]     cur_l2_bit, cur_sum_bit, upd_bit;
    logic [WORD_BITS-1:0] new_word, new_sum, new_l2;

    // Bitmap proper, one bit per page.
    pba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // First summary level, one bit per map word that still holds a free page.
    pba_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_WORDS)) u_sum (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    assign status.clearing = state_reg == ST_CLEAR;
    assign out_free        = !out_valid_reg || m_ready;

    // Index fields of the word being worked on.
    assign cur_top     = word_idx_reg[MAP_AW-1 -: TOP_AW];
    assign cur_l2_bit  = word_idx_reg[2*BIT_W-1:BIT_W];
    assign cur_sum_bit = word_idx_reg[BIT_W-1:0];

    // Priority encoders of the search steps.
    assign top_low = lowest_set(WORD_BITS'(top_reg));
    assign top_sel = TOP_AW'(top_low);
    assign l2_low  = lowest_set(l2_reg[cur_top]);
    assign sum_low = lowest_set(sum_rdata);
    assign map_low = lowest_set(map_rdata);

    // New contents of the touched word and of each summary level above it.
    always_comb begin
        upd_bit = (kind_reg == KIND_ALLOC) ? map_low : bit_idx_reg;
        new_word = map_rdata;
        new_word[upd_bit] = (kind_reg == KIND_SET);
        new_sum = sum_rdata;
        new_sum[cur_sum_bit] = |new_word;
        new_l2 = l2_reg[cur_top];
        new_l2[cur_l2_bit] = |new_sum;
    end

    // Sequencer of the back part.
    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        kind_next      = kind_reg;
        word_idx_next  = word_idx_reg;
        bit_idx_next   = bit_idx_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_found_next = out_found_reg;
        out_page_next  = out_page_reg;
        q_ready        = 1'b0;
        map_we         = 1'b0;
        map_waddr      = word_idx_reg;
        map_wdata      = new_word;
        map_raddr      = word_idx_reg;
        sum_we         = 1'b0;
        sum_waddr      = word_idx_reg[MAP_AW-1:BIT_W];
        sum_wdata      = new_sum;
        sum_raddr      = word_idx_reg[MAP_AW-1:BIT_W];
        l2_we          = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                map_wdata = '0;
                sum_we    = clr_cnt_reg < MAP_AW'(SUM_WORDS);
                sum_waddr = SUM_AW'(clr_cnt_reg);
                sum_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == MAP_AW'(MAP_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    kind_next     = q_cmd.kind;
                    word_idx_next = q_cmd.word_idx;
                    bit_idx_next  = q_cmd.bit_idx;
                    unique case (q_cmd.kind)
                        KIND_NOP: begin
                            if (out_free) begin
                                q_ready        = 1'b1;
                                out_valid_next = 1'b1;
                                out_found_next = 1'b0;
                                out_page_next  = '0;
                            end
                        end
                        KIND_ALLOC: begin
                            q_ready    = 1'b1;
                            state_next = ST_FIND_TOP;
                        end
                        default: begin
                            q_ready    = 1'b1;
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_FIND_TOP: begin
                // An empty top level means no free page anywhere.
                if (top_reg == '0) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_found_next = 1'b0;
                        out_page_next  = '0;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    word_idx_next = {top_sel, {(MAP_AW - TOP_AW){1'b0}}};
                    state_next    = ST_FIND_SUM;
                end
            end
            ST_FIND_SUM: begin
                word_idx_next = {cur_top, l2_low, {BIT_W{1'b0}}};
                sum_raddr     = SUM_AW'({cur_top, l2_low});
                state_next    = ST_FIND_WORD;
            end
            ST_FIND_WORD: begin
                word_idx_next = {word_idx_reg[MAP_AW-1:BIT_W], sum_low};
                map_raddr     = {word_idx_reg[MAP_AW-1:BIT_W], sum_low};
                state_next    = ST_UPDATE;
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    map_we = 1'b1;
                    sum_we = 1'b1;
                    l2_we  = 1'b1;
                    top_next[cur_top] = |new_l2;
                    out_valid_next = 1'b1;
                    out_found_next = kind_reg == KIND_ALLOC;
                    out_page_next  = (kind_reg == KIND_ALLOC)
                                   ? PAGE_W'({word_idx_reg, map_low}) : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TOP_WORDS; i++) begin
                l2_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            if (l2_we) begin
                l2_reg[cur_top] <= new_l2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        word_idx_reg  <= word_idx_next;
        bit_idx_reg   <= bit_idx_next;
        out_found_reg <= out_found_next;
        out_page_reg  <= out_page_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_found        = out_found_reg;
    assign m_granted_page = out_page_reg;

endmodule

FILE: src/page_bitmap_allocator_unit.sv
// Top level of the first-fit page bitmap allocator.
//
// The block keeps one bit per 4 KiB page (1 free, 0 used) and serves requests on
// a valid/ready input channel (s_action, s_page_number). Each request gives exactly
// one result on a valid/ready output channel (m_found, m_granted_page).
// Allocate hands out the lowest-numbered free page and marks it used; free and
// mark-used set or clear the named page's bit and return found = 0, page 0.
// A front part classifies requests into a two-entry queue; a back part runs them.
// Free and mark-used pass the states READ and UPDATE; an allocate walks FIND_TOP,
// FIND_SUM, FIND_WORD and UPDATE, or ends after FIND_TOP when no page is free; an
// unused code goes from IDLE straight to the output register. The back part handles
// one request at a time, taking no new one until the last is through; the allocate
// walks a 32-bit top summary, a flip-flop summary level and the summary and bitmap
// memories, each with a registered read.
// After reset a clearing pass writes zeros through the whole bitmap, one word a
// cycle (MAP_WORDS = 32768 words); s_ready stays low until it ends.
// A stalled receiver holds the result in the output register; the queue keeps
// accepting until it is full.
`timescale 1ns / 1ps
module page_bitmap_allocator_unit import pba_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [PAGE_W-1:0]   s_page_number,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found,
    output logic [PAGE_W-1:0]   m_granted_page
);

    pba_status_t status;
    pba_cmd_t    q_cmd;
    logic        q_valid;
    logic        q_ready;

    // Request intake and classification.
    pba_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_page_number (s_page_number),
        .status        (status),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd)
    );

    // Map storage, search and update.
    pba_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_cmd          (q_cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_granted_page (m_granted_page)
    );

    // No request enters while the clearing pass runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("request accepted during the clearing pass");

    // A reset always restarts the clearing pass.
    assert property (@(posedge aclk)
        !aresetn |=> status.clearing)
        else $error("clearing pass not started after reset");

    // A result without a page carries page number zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_granted_page == '0)
        else $error("non-zero page on a result without a grant");

    // The queue only hands commands over once the map is ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !q_ready)
        else $error("command taken from the queue during clearing");

endmodule

FILE: tb/sv/page_grant_checker.sv
// Checker that predicts and compares every result of the page bitmap allocator.
`timescale 1ns / 1ps
module page_grant_checker import pba_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [PAGE_W-1:0]   s_page_number,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_found,
    input  logic [PAGE_W-1:0]   m_granted_page,
    output int                  mismatch_count,
    output int                  outstanding,
    output int                  results_checked,
    output int                  grant_count
);

    typedef struct {
        logic              found;
        logic [PAGE_W-1:0] page;
    } grant_t;

    // Free pages grouped by map word; only words holding a free page are kept,
    // so the lowest key is always the first word worth scanning.
    logic [WORD_BITS-1:0] free_words [int];
    grant_t               awaited_grants [$];

    initial begin
        mismatch_count  = 0;
        outstanding     = 0;
        results_checked = 0;
        grant_count     = 0;
    end

    // Sets or clears one page bit; pages beyond the map are ignored.
    function automatic void set_page_state(input logic [PAGE_W-1:0] page,
                                           input logic make_free);
        int                   word;
        int                   bit_pos;
        logic [WORD_BITS-1:0] bits;
        word    = int'(page) / WORD_BITS;
        bit_pos = int'(page) % WORD_BITS;
        if (word >= MAP_WORDS) begin
            return;
        end
        bits = free_words.exists(word) ? free_words[word] : '0;
        bits[bit_pos] = make_free;
        if (bits == '0) begin
            if (free_words.exists(word)) begin
                free_words.delete(word);
            end
        end else begin
            free_words[word] = bits;
        end
    endfunction

    // First fit: lowest free word, then its lowest free bit.
    function automatic grant_t claim_lowest_free_page();
        grant_t               grant;
        int                   word;
        int                   lowest;
        logic [WORD_BITS-1:0] bits;
        grant.found = 1'b0;
        grant.page  = '0;
        if (free_words.first(word)) begin
            bits   = free_words[word];
            lowest = 0;
            for (int b = 0; b < WORD_BITS; b++) begin
                if (bits[b]) begin
                    lowest = b;
                    break;
                end
            end
            set_page_state(PAGE_W'(word * WORD_BITS + lowest), 1'b0);
            grant.found = 1'b1;
            grant.page  = PAGE_W'(word * WORD_BITS + lowest);
        end
        return grant;
    endfunction

    // Applies one request to the map and returns the result it should give.
    function automatic grant_t predict_grant(input logic [ACTION_W-1:0] action,
                                             input logic [PAGE_W-1:0] page);
        grant_t grant;
        grant.found = 1'b0;
        grant.page  = '0;
        case (action)
            ACT_ALLOC: begin
                grant = claim_lowest_free_page();
            end
            ACT_FREE: begin
                set_page_state(page, 1'b1);
            end
            ACT_MARK: begin
                set_page_state(page, 1'b0);
            end
            default: begin
            end
        endcase
        return grant;
    endfunction

    function automatic void log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endfunction

    // Results are checked before requests so that a result never meets an
    // expectation queued in the same cycle.
    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            free_words.delete();
            awaited_grants.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (awaited_grants.size() == 0) begin
                    log_mismatch($sformatf("unexpected result found=%0b page=0x%05h",
                                           m_found, m_granted_page));
                end else begin
                    want = awaited_grants.pop_front();
                    if (want.found) begin
                        grant_count++;
                    end
                    if (m_found !== want.found || m_granted_page !== want.page) begin
                        log_mismatch($sformatf(
                            "expected found=%0b page=0x%05h, got found=%0b page=0x%05h",
                            want.found, want.page, m_found, m_granted_page));
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_grants.push_back(predict_grant(s_action, s_page_number));
            end
        end
        outstanding = awaited_grants.size();
    end

endmodule

FILE: tb/sv/page_bitmap_allocator_unit_test.sv
// Stimulus, clocking and verdict for the page bitmap allocator testbench.
`timescale 1ns / 1ps
module page_bitmap_allocator_unit_test import pba_pkg::*; ();

    localparam logic [ACTION_W-1:0] ACT_UNUSED     = 2'd3;
    localparam int                  WATCHDOG_LIMIT = 200000;
    localparam logic [PAGE_W-1:0]   TOP_PAGE       = {PAGE_W{1'b1}};

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action      = '0;
    logic [PAGE_W-1:0]   s_page_number = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_found;
    logic [PAGE_W-1:0]   m_granted_page;

    int mismatch_count;
    int outstanding;
    int results_checked;
    int grant_count;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int idle_cycles   = 0;
    int alloc_sent    = 0;
    int free_sent     = 0;
    int mark_sent     = 0;
    int unused_sent   = 0;

    page_bitmap_allocator_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_granted_page (m_granted_page)
    );

    page_grant_checker grant_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_granted_page  (m_granted_page),
        .mismatch_count  (mismatch_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .grant_count     (grant_count)
    );

    always #10 aclk = ~aclk;

    // The result side stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Ends the run when no request or result has moved for too long; the
    // limit covers the clearing pass after reset.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog expired with %0d results outstanding",
                     $time, outstanding);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request after a random gap and holds it until accepted.
    // Ready is sampled at the falling edge, where it is stable.
    task automatic issue_request(input logic [ACTION_W-1:0] action,
                                 input logic [PAGE_W-1:0] page);
        logic ready_seen;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= action;
        s_page_number <= page;
        forever begin
            @(negedge aclk);
            ready_seen = s_ready;
            @(posedge aclk);
            if (ready_seen) begin
                break;
            end
        end
        case (action)
            ACT_ALLOC: alloc_sent++;
            ACT_FREE:  free_sent++;
            ACT_MARK:  mark_sent++;
            default:   unused_sent++;
        endcase
    endtask

    // Largely a low window so that frees and allocations collide, some pages
    // at the top of the range, and the rest anywhere.
    function automatic logic [PAGE_W-1:0] pick_page();
        int region;
        region = $urandom_range(0, 99);
        if (region < 60) begin
            return PAGE_W'($urandom_range(0, 511));
        end else if (region < 75) begin
            return TOP_PAGE - PAGE_W'($urandom_range(0, 511));
        end
        return PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
    endfunction

    // Random mix of requests; the unused code does not count towards the quota.
    task automatic run_random_mix(input int quota);
        int                  counted;
        int                  pick;
        logic [ACTION_W-1:0] action;
        counted = 0;
        while (counted < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                action = ACT_ALLOC;
            end else if (pick < 72) begin
                action = ACT_FREE;
            end else if (pick < 95) begin
                action = ACT_MARK;
            end else begin
                action = ACT_UNUSED;
            end
            issue_request(action, pick_page());
            if (action != ACT_UNUSED) begin
                counted++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty map, unused code, both ends of the page range,
        // a word boundary, repeated frees and marks, and a map run dry.
        src_idle_pct  = 30;
        sink_idle_pct = 59;
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_UNUSED, 20'd5);
        issue_request(ACT_FREE, '0);
        issue_request(ACT_ALLOC, TOP_PAGE);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_FREE, TOP_PAGE);
        issue_request(ACT_FREE, 20'd31);
        issue_request(ACT_FREE, 20'd32);
        issue_request(ACT_FREE, 20'd31);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_MARK, 20'd32);
        issue_request(ACT_MARK, 20'd32);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_FREE, 20'hAAAAA);
        issue_request(ACT_FREE, 20'h55555);
        issue_request(ACT_FREE, 20'h7FFFF);
        issue_request(ACT_FREE, 20'h80000);
        issue_request(ACT_MARK, 20'h55555);
        issue_request(ACT_UNUSED, 20'h7FFFF);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_ALLOC, '0);
        issue_request(ACT_ALLOC, '0);

        // Random part in three phases of idling.
        run_random_mix(300);
        src_idle_pct  = 59;
        sink_idle_pct = 30;
        run_random_mix(300);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random_mix(300);
        s_valid <= 1'b0;

        // Drain the results, then let anything stray arrive before the verdict.
        do begin
            @(negedge aclk);
        end while (outstanding != 0);
        repeat (20) @(posedge aclk);

        $display("Covered %0d allocate, %0d free, %0d mark-used and %0d unused-code requests.",
                 alloc_sent, free_sent, mark_sent, unused_sent);
        $display("Checked %0d results, %0d of them granted pages, %0d mismatches.",
                 results_checked, grant_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: page_bitmap_allocator_unit.f
src/pba_pkg.sv
src/pba_ram.sv
src/pba_front.sv
src/pba_back.sv
src/page_bitmap_allocator_unit.sv
tb/sv/page_grant_checker.sv
tb/sv/page_bitmap_allocator_unit_test.sv
